// ===== hw/rtl/mpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mpq_pkg: shared definitions for the keyed minimum priority queue
// Operation, status and cell command codes, the neighbor flag bundle and
// the default sizes used by the queue and its cells.
// ----------------------------------------------------------------------------
package mpq_pkg;

    // Default sizes and fixed field widths.
    localparam int DEPTH_DEF    = 64;
    localparam int KEY_BITS_DEF = 8;
    localparam int FUNC_W       = 2;
    localparam int PORT_KEY_W   = 8;
    localparam int PRIO_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int TOTAL_W      = 7;
    localparam int CMD_W        = 3;

    // Operation codes carried by a request word.
    localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEQUEUE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE  = 2'd2;

    // Status codes carried by a result word.
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DEQ_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INS_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_KEY_MISSING = 2'd3;

    // Commands broadcast from the sequencer to every cell.
    typedef logic [CMD_W-1:0] cmd_t;
    localparam cmd_t CMD_NOP       = 3'd0;
    localparam cmd_t CMD_DEQ       = 3'd1;
    localparam cmd_t CMD_REM_START = 3'd2;
    localparam cmd_t CMD_REM_STEP  = 3'd3;
    localparam cmd_t CMD_INS       = 3'd4;

    // Flags a cell shows to its neighbors.
    typedef struct packed {
        logic valid;   // cell holds an entry
        logic take;    // cell would accept a new or shifted entry on insert
        logic hole;    // cell is pulling from its right neighbor this cycle
    } nbr_t;

endpackage

// ===== hw/rtl/mpq_cell.sv =====
// ----------------------------------------------------------------------------
// mpq_cell: one slot of the sorted queue
// Holds one (key, priority) entry and moves it to or from its neighbors on
// dequeue, removal and insert commands.
// ----------------------------------------------------------------------------
module mpq_cell
    import mpq_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    input  logic [KEY_BITS-1:0] op_key,
    input  logic [PRIO_W-1:0]   op_prio,
    input  nbr_t                left_flags,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic [PRIO_W-1:0]   left_prio,
    input  nbr_t                right_flags,
    input  logic [KEY_BITS-1:0] right_key,
    input  logic [PRIO_W-1:0]   right_prio,
    output nbr_t                own_flags,
    output logic [KEY_BITS-1:0] own_key,
    output logic [PRIO_W-1:0]   own_prio,
    output logic                match,
    output logic                pending
);

    logic                valid_reg, valid_next;
    logic                hole_reg, hole_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [PRIO_W-1:0]   prio_reg, prio_next;
    logic                take;
    logic                pull;

    // Local compares: key match and insert position.
    assign match = valid_reg && (key_reg == op_key);
    assign take  = !valid_reg || (prio_reg > op_prio);
    assign pull  = ((cmd == CMD_REM_START) && match) ||
                   ((cmd == CMD_REM_STEP) && hole_reg);

    assign own_flags = '{valid: valid_reg, take: take, hole: pull};
    assign own_key   = key_reg;
    assign own_prio  = prio_reg;
    assign pending   = hole_reg;

    // Next contents for each command.
    always_comb begin
        valid_next = valid_reg;
        hole_next  = hole_reg;
        key_next   = key_reg;
        prio_next  = prio_reg;
        case (cmd)
            CMD_DEQ: begin
                valid_next = right_flags.valid;
                key_next   = right_key;
                prio_next  = right_prio;
                hole_next  = 1'b0;
            end
            CMD_REM_START, CMD_REM_STEP: begin
                if (pull) begin
                    valid_next = right_flags.valid;
                    key_next   = right_key;
                    prio_next  = right_prio;
                end
                // The gap moves here when the left cell pulled a live entry.
                hole_next = left_flags.hole && valid_reg;
            end
            CMD_INS: begin
                hole_next = 1'b0;
                if (take) begin
                    if (left_flags.take) begin
                        valid_next = left_flags.valid;
                        key_next   = left_key;
                        prio_next  = left_prio;
                    end else begin
                        valid_next = 1'b1;
                        key_next   = op_key;
                        prio_next  = op_prio;
                    end
                end
            end
            default: begin
                valid_next = valid_reg;
            end
        endcase
    end

    // Control flags are reset; the payload is not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hole_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            hole_reg  <= hole_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        prio_reg <= prio_next;
    end

endmodule

// ===== hw/rtl/min_priority_queue_keyed_top.sv =====
// ----------------------------------------------------------------------------
// min_priority_queue_keyed_top: keyed minimum priority queue
// Sorted row of cells with insert, dequeue-minimum and update-by-key.
// ----------------------------------------------------------------------------
// A request word (s_func, s_item_key, s_item_priority) is taken when s_valid
// and s_ready are high. Each request produces exactly one result word on the
// m_ channel: the dequeued entry (zero otherwise), a status code, the entry
// count after the operation and an empty flag.
// Entries sit in a row of DEPTH cells sorted by ascending priority; equal
// priorities keep arrival order. Dequeue shifts the whole row left and insert
// shifts the tail right, each with all cells moving together.
// An update, or an insert of a key already held, first closes the gap left
// by the old entry one cell per cycle, then inserts again.
// s_ready is high only while no request is in work, so a new request is not
// taken until the result of the last one has gone to the output register.
// The result sits in an output register; a stalled receiver does not stop
// the next request from being taken, but the one after waits until the
// result register is free.
// Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module min_priority_queue_keyed_top
    import mpq_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [FUNC_W-1:0]     s_func,
    input  logic [PORT_KEY_W-1:0] s_item_key,
    input  logic [PRIO_W-1:0]     s_item_priority,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PORT_KEY_W-1:0] m_out_key,
    output logic [PRIO_W-1:0]     m_out_priority,
    output logic [STATUS_W-1:0]   m_status,
    output logic [TOTAL_W-1:0]    m_entry_total,
    output logic                  m_is_empty
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_REMOVE = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [FUNC_W-1:0]     op_func_reg;
    logic [KEY_BITS-1:0]   op_key_reg;
    logic [PRIO_W-1:0]     op_prio_reg;
    logic [KEY_BITS-1:0]   res_key_reg, res_key_next;
    logic [PRIO_W-1:0]     res_prio_reg, res_prio_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  m_valid_reg, m_valid_next;
    logic [PORT_KEY_W-1:0] m_key_reg;
    logic [PRIO_W-1:0]     m_prio_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [TOTAL_W-1:0]    m_total_reg;
    logic                  m_empty_reg;
    logic                  s_accept;
    logic                  out_free;
    logic                  found;
    logic                  any_pending;
    cmd_t                  cmd;

    nbr_t                  flags    [DEPTH];
    logic [KEY_BITS-1:0]   keys     [DEPTH];
    logic [PRIO_W-1:0]     prios    [DEPTH];
    logic [DEPTH-1:0]      match_vec;
    logic [DEPTH-1:0]      pend_vec;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Row of cells; the ends see an empty neighbor.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        nbr_t                left_f, right_f;
        logic [KEY_BITS-1:0] left_k, right_k;
        logic [PRIO_W-1:0]   left_p, right_p;

        if (i == 0) begin : g_first
            assign left_f = '0;
            assign left_k = '0;
            assign left_p = '0;
        end else begin : g_mid_l
            assign left_f = flags[i-1];
            assign left_k = keys[i-1];
            assign left_p = prios[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_f = '0;
            assign right_k = '0;
            assign right_p = '0;
        end else begin : g_mid_r
            assign right_f = flags[i+1];
            assign right_k = keys[i+1];
            assign right_p = prios[i+1];
        end

        mpq_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .op_key      (op_key_reg),
            .op_prio     (op_prio_reg),
            .left_flags  (left_f),
            .left_key    (left_k),
            .left_prio   (left_p),
            .right_flags (right_f),
            .right_key   (right_k),
            .right_prio  (right_p),
            .own_flags   (flags[i]),
            .own_key     (keys[i]),
            .own_prio    (prios[i]),
            .match       (match_vec[i]),
            .pending     (pend_vec[i])
        );
    end

    assign found       = |match_vec;
    assign any_pending = |pend_vec;

    // Sequencer: decides the command for the row and the result fields.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        cmd             = CMD_NOP;
        res_key_next    = res_key_reg;
        res_prio_next   = res_prio_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_key_next    = '0;
                res_prio_next   = '0;
                res_status_next = ST_OK;
                state_next      = S_FINISH;
                case (op_func_reg)
                    FUNC_DEQUEUE: begin
                        if (count_reg == '0) begin
                            res_status_next = ST_DEQ_EMPTY;
                        end else begin
                            res_key_next  = keys[0];
                            res_prio_next = prios[0];
                            cmd           = CMD_DEQ;
                            count_next    = count_reg - 1'b1;
                        end
                    end
                    FUNC_INSERT, FUNC_UPDATE: begin
                        if (found) begin
                            cmd        = CMD_REM_START;
                            count_next = count_reg - 1'b1;
                            state_next = S_REMOVE;
                        end else if (op_func_reg == FUNC_UPDATE) begin
                            res_status_next = ST_KEY_MISSING;
                        end else if (count_reg == CNT_W'(DEPTH)) begin
                            res_status_next = ST_INS_FULL;
                        end else begin
                            cmd        = CMD_INS;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    default: begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            S_REMOVE: begin
                if (any_pending) begin
                    cmd = CMD_REM_STEP;
                end else begin
                    cmd        = CMD_INS;
                    count_next = count_reg + 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if ((state_reg == S_FINISH) && out_free) begin
            m_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Request, working result and output payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_func_reg <= s_func;
            op_key_reg  <= KEY_BITS'(32'(s_item_key));
            op_prio_reg <= s_item_priority;
        end
        res_key_reg    <= res_key_next;
        res_prio_reg   <= res_prio_next;
        res_status_reg <= res_status_next;
        if ((state_reg == S_FINISH) && out_free) begin
            m_key_reg    <= PORT_KEY_W'(32'(res_key_reg));
            m_prio_reg   <= res_prio_reg;
            m_status_reg <= res_status_reg;
            m_total_reg  <= TOTAL_W'(32'(count_reg));
            m_empty_reg  <= (count_reg == '0);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_key      = m_key_reg;
    assign m_out_priority = m_prio_reg;
    assign m_status       = m_status_reg;
    assign m_entry_total  = m_total_reg;
    assign m_is_empty     = m_empty_reg;

endmodule

// ===== test/min_priority_queue_keyed_top_tb.sv =====
// ----------------------------------------------------------------------------
// min_priority_queue_keyed_top_tb: regression bench for the keyed min queue
// Drives insert, dequeue, update and unused operation words through the
// request channel and mirrors the sorted entry list in a small scoreboard.
// Every result word is checked field by field against the mirror, with random
// idling on both channels in all but the last third of the random phase.
// ----------------------------------------------------------------------------
module min_priority_queue_keyed_top_tb;
    import mpq_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [PRIO_W-1:0] PRIO_MAX    = '1;
    localparam int RAND_ITEMS = 650;
    localparam int BURST_LEN  = 120;

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [FUNC_W-1:0]     s_func          = FUNC_INSERT;
    logic [PORT_KEY_W-1:0] s_item_key      = '0;
    logic [PRIO_W-1:0]     s_item_priority = '0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [PORT_KEY_W-1:0] m_out_key;
    logic [PRIO_W-1:0]     m_out_priority;
    logic [STATUS_W-1:0]   m_status;
    logic [TOTAL_W-1:0]    m_entry_total;
    logic                  m_is_empty;

    int send_idle_pct  = 8;
    int recv_stall_pct = 66;

    // One result word as the block should return it.
    typedef struct packed {
        logic [PORT_KEY_W-1:0] key;
        logic [PRIO_W-1:0]     prio;
        logic [STATUS_W-1:0]   status;
        logic [TOTAL_W-1:0]    total;
        logic                  is_empty;
    } result_word_t;

    // Mirror of the sorted entry list plus the results still owed by the block.
    class queue_mirror;
        logic [PORT_KEY_W-1:0] keys [DEPTH_DEF];
        logic [PRIO_W-1:0]     prios [DEPTH_DEF];
        int                    count;
        int                    errors;
        result_word_t          owed[$];

        function new();
            count  = 0;
            errors = 0;
        endfunction

        // Close the gap at pos by shifting the tail left.
        function void drop(int pos);
            for (int i = pos; i < count - 1; i++) begin
                keys[i]  = keys[i + 1];
                prios[i] = prios[i + 1];
            end
            count--;
        endfunction

        // Insert behind every entry of equal or smaller priority.
        function void place(logic [PORT_KEY_W-1:0] k, logic [PRIO_W-1:0] p);
            int pos;
            pos = 0;
            while (pos < count && prios[pos] <= p) pos++;
            for (int i = count; i > pos; i--) begin
                keys[i]  = keys[i - 1];
                prios[i] = prios[i - 1];
            end
            keys[pos]  = k;
            prios[pos] = p;
            count++;
        endfunction

        // Apply one accepted request word and queue the result it owes.
        function void take_request(logic [FUNC_W-1:0] f, logic [PORT_KEY_W-1:0] k,
                                   logic [PRIO_W-1:0] p);
            result_word_t r;
            int           pos;
            r        = '0;
            r.status = ST_OK;
            pos      = -1;
            for (int i = 0; i < count; i++) begin
                if (pos < 0 && keys[i] == k) pos = i;
            end
            case (f)
                FUNC_INSERT, FUNC_UPDATE: begin
                    if (pos >= 0) begin
                        drop(pos);
                        place(k, p);
                    end else if (f == FUNC_UPDATE) begin
                        r.status = ST_KEY_MISSING;
                    end else if (count >= DEPTH_DEF) begin
                        r.status = ST_INS_FULL;
                    end else begin
                        place(k, p);
                    end
                end
                FUNC_DEQUEUE: begin
                    if (count == 0) begin
                        r.status = ST_DEQ_EMPTY;
                    end else begin
                        r.key  = keys[0];
                        r.prio = prios[0];
                        drop(0);
                    end
                end
                default: ;
            endcase
            r.total    = count[TOTAL_W-1:0];
            r.is_empty = (count == 0);
            owed.push_back(r);
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        // Check a result word against the oldest owed result.
        function void match_result(result_word_t got);
            result_word_t want;
            if (owed.size() == 0) begin
                $error("result word with no request pending");
                errors++;
            end else begin
                want = owed.pop_front();
                compare_field("out_key", 64'(want.key), 64'(got.key));
                compare_field("out_priority", 64'(want.prio), 64'(got.prio));
                compare_field("status", 64'(want.status), 64'(got.status));
                compare_field("entry_total", 64'(want.total), 64'(got.total));
                compare_field("is_empty", 64'(want.is_empty), 64'(got.is_empty));
            end
        endfunction
    endclass

    queue_mirror mirror = new();

    min_priority_queue_keyed_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_item_key      (s_item_key),
        .s_item_priority (s_item_priority),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_key       (m_out_key),
        .m_out_priority  (m_out_priority),
        .m_status        (m_status),
        .m_entry_total   (m_entry_total),
        .m_is_empty      (m_is_empty)
    );

    // Free-running clock.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("min_priority_queue_keyed_top regression: fail");
        $finish;
    end

    // Receiver back-pressure, redrawn every cycle.
    initial begin
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Check each result word as it is taken.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            mirror.match_result('{key: m_out_key, prio: m_out_priority, status: m_status,
                                  total: m_entry_total, is_empty: m_is_empty});
        end
    end

    // Present one request word, with random idle cycles ahead of it, and wait
    // until the block takes it.
    task automatic send_word(logic [FUNC_W-1:0] f, logic [PORT_KEY_W-1:0] k,
                             logic [PRIO_W-1:0] p);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_func          <= f;
        s_item_key      <= k;
        s_item_priority <= p;
        do @(posedge aclk); while (!s_ready);
        mirror.take_request(f, k, p);
    endtask

    // Priorities lean toward small values so that ties are common.
    function automatic logic [PRIO_W-1:0] pick_priority();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return $urandom_range(0, 15);
        if (r < 50) begin
            case ($urandom_range(0, 2))
                0:       return '0;
                1:       return PRIO_MAX;
                default: return PRIO_MAX - 1;
            endcase
        end
        return $urandom();
    endfunction

    // Take a key already held with the given odds, else any key.
    function automatic logic [PORT_KEY_W-1:0] pick_key(int held_pct);
        if (mirror.count > 0 && $urandom_range(0, 99) < held_pct) begin
            return mirror.keys[$urandom_range(0, mirror.count - 1)];
        end
        return PORT_KEY_W'($urandom_range(0, 255));
    endfunction

    initial begin
        int                    target;
        int                    r;
        logic [FUNC_W-1:0]     f;
        logic [PORT_KEY_W-1:0] k;

        target = 0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty and missing-key cases, ties, re-keying, drain.
        send_word(FUNC_DEQUEUE, 8'h00, 32'h0);
        send_word(FUNC_UPDATE, 8'hFF, 32'h5);
        send_word(FUNC_UNUSED, 8'hFF, PRIO_MAX);
        send_word(FUNC_INSERT, 8'h00, PRIO_MAX);
        send_word(FUNC_INSERT, 8'hFF, 32'h0);
        send_word(FUNC_INSERT, 8'h55, 32'd100);
        send_word(FUNC_INSERT, 8'hAA, 32'd100);
        send_word(FUNC_INSERT, 8'h01, 32'd100);
        // Re-inserting a held key moves it behind its equals.
        send_word(FUNC_INSERT, 8'h55, 32'd100);
        send_word(FUNC_UPDATE, 8'hAA, 32'h0);
        send_word(FUNC_UPDATE, 8'h00, 32'h0);
        send_word(FUNC_INSERT, 8'hFF, PRIO_MAX);
        send_word(FUNC_UNUSED, 8'h00, 32'h0);
        repeat (6) send_word(FUNC_DEQUEUE, 8'h00, 32'h0);
        send_word(FUNC_UPDATE, 8'h55, 32'd7);

        // Random: bursts that fill to full, drain to empty or hover.
        for (int i = 0; i < RAND_ITEMS; i++) begin
            case (i * 3 / RAND_ITEMS)
                0: begin
                    send_idle_pct  = 8;
                    recv_stall_pct = 66;
                end
                1: begin
                    send_idle_pct  = 66;
                    recv_stall_pct = 8;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            if (i % BURST_LEN == 0) begin
                case ((i / BURST_LEN) % 3)
                    0:       target = DEPTH_DEF;
                    1:       target = 0;
                    default: target = $urandom_range(1, DEPTH_DEF - 1);
                endcase
            end
            r = $urandom_range(0, 99);
            if (mirror.count < target) begin
                if (r < 3)       f = FUNC_UNUSED;
                else if (r < 10) f = FUNC_UPDATE;
                else if (r < 90) f = FUNC_INSERT;
                else             f = FUNC_DEQUEUE;
            end else begin
                if (r < 3)       f = FUNC_UNUSED;
                else if (r < 15) f = FUNC_UPDATE;
                else if (r < 40) f = FUNC_INSERT;
                else             f = FUNC_DEQUEUE;
            end
            case (f)
                FUNC_UPDATE: k = pick_key(75);
                FUNC_INSERT: k = pick_key(20);
                default:     k = PORT_KEY_W'($urandom_range(0, 255));
            endcase
            send_word(f, k, pick_priority());
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain the owed results, then give stray words time to show up.
        while (mirror.owed.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        if (mirror.errors == 0) begin
            $display("min_priority_queue_keyed_top regression: pass");
        end else begin
            $display("min_priority_queue_keyed_top regression: fail");
        end
        $finish;
    end

endmodule
